FILE: rtl/sphere_of_influence_graph_assert.svh
// assertion macros for the sphere-of-influence graph block
// expects clk and rst_n in the scope where a macro is used
`ifndef SPHERE_OF_INFLUENCE_GRAPH_ASSERT_SVH
`define SPHERE_OF_INFLUENCE_GRAPH_ASSERT_SVH

// property checked at every clock edge outside reset
`define SOIG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked in the cycle after a trigger
`define SOIG_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/soig_pkg.sv
// shared types and constants of the sphere-of-influence graph block
// no dependencies
package soig_pkg;

    localparam int COORD_W        = 16;
    localparam int DIMS_W         = 5;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 5'd2;
    localparam int VERTEX_W       = 6;
    localparam int NEIGH_W        = 64;
    localparam int SQ_W           = 32;
    localparam int DIST_W         = 38;
    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 72;
    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DIMS_DEF   = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW_START,
        ST_ROW_CAP,
        ST_PAIR_CHK,
        ST_ADDR,
        ST_DATA,
        ST_ACC,
        ST_CMP,
        ST_ROW_END,
        ST_OUT
    } state_t;

endpackage

FILE: rtl/soig_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module soig_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/sphere_of_influence_graph.sv
// sphere-of-influence graph: loads points, emits one neighbor mask row per point
// depends on soig_pkg, soig_ram and sphere_of_influence_graph_assert.svh
// load: one coordinate request per cycle; after end_of_set of a non-empty set the input stalls
// compute: each pass runs over all ordered pairs of the n points of d coordinates, set
// by the single subtract/square/accumulate unit stepping one coordinate through ADDR, DATA, ACC
// rows leave one per row compute; reset clears control, store needs no clearing pass
`include "sphere_of_influence_graph_assert.svh"

module sphere_of_influence_graph #(
    parameter int MAX_POINTS = soig_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS   = soig_pkg::MAX_DIMS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration: dims_in_use
    input  logic                               cfg_we,
    input  logic [soig_pkg::DIMS_W-1:0]        cfg_wdata,
    // input stream, tdata: coord[15:0]; tlast: end_of_set
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [soig_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                               s_axis_tlast,
    // output stream, tdata: vertex[5:0], neighbors[69:6], overflow[70], zero[71]
    // tlast: last_row
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [soig_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast
);

    localparam int PI_W  = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SA_W  = $clog2(MAX_POINTS * MAX_DIMS);
    localparam int DW    = soig_pkg::DIST_W;
    localparam int CW    = soig_pkg::COORD_W;

    // control state
    soig_pkg::state_t            state_reg, state_next;
    logic                        pass_reg, pass_next;      // 0 nearest search, 1 linking
    logic [PI_W-1:0]             i_reg, i_next;            // row point
    logic [CNT_W-1:0]            j_reg, j_next;            // partner point
    logic [IDX_W-1:0]            k_reg, k_next;            // coordinate step
    logic [CNT_W-1:0]            count_reg, count_next;    // complete points held
    logic [IDX_W-1:0]            cidx_reg, cidx_next;      // coordinate within point
    logic                        dropped_reg, dropped_next;
    logic [soig_pkg::DIMS_W-1:0] dims_reg;
    logic                        out_valid_reg, out_valid_next;

    // datapath
    logic [DW-1:0]               acc_reg, acc_next;
    logic [soig_pkg::SQ_W-1:0]   sq_reg, sq_next;
    logic [DW-1:0]               min_reg, min_next;
    logic [DW-1:0]               near_i_reg, near_i_next;
    logic [MAX_POINTS-1:0]       mask_reg, mask_next;
    logic [soig_pkg::VERTEX_W-1:0] out_vertex_reg, out_vertex_next;
    logic [soig_pkg::NEIGH_W-1:0]  out_neigh_reg, out_neigh_next;
    logic                        out_ovf_reg, out_ovf_next;
    logic                        out_last_reg, out_last_next;

    logic                        in_req;
    logic                        full;
    logic                        point_close;
    logic [CNT_W-1:0]            count_upd;
    logic [IDX_W-1:0]            eff_dm1;
    logic                        out_free;
    logic                        k_last;
    logic                        j_is_end;
    logic                        j_is_i;
    logic                        i_is_last;
    logic                        row_out_last;
    logic                        set_closed;

    logic [SA_W-1:0]             st_waddr, st_raddr_a, st_raddr_b;
    logic                        st_we;
    logic [CW-1:0]               st_rd_a, st_rd_b;
    logic [PI_W-1:0]             near_raddr;
    logic                        near_we;
    logic [DW-1:0]               near_rd;

    logic signed [CW:0]          diff;
    logic [CW:0]                 diff_neg;
    logic [CW-1:0]               mag;
    logic [DW:0]                 thr;
    logic                        link;
    logic [PI_W-1:0]             j_idx;

    // last coordinate index in force, with zero read as one and clipped to capacity
    always_comb
    begin
        priority if (dims_reg == '0)
        begin
            eff_dm1 = '0;
        end
        else if (int'(dims_reg) > MAX_DIMS)
        begin
            eff_dm1 = IDX_W'(MAX_DIMS - 1);
        end
        else
        begin
            eff_dm1 = IDX_W'(dims_reg - 5'd1);
        end
    end

    assign in_req      = s_axis_tvalid && s_axis_tready;
    assign full        = (count_reg >= CNT_W'(MAX_POINTS));
    assign point_close = (cidx_reg >= eff_dm1);
    assign count_upd   = (point_close && !full) ? count_reg + 1'b1 : count_reg;
    assign out_free    = !out_valid_reg || m_axis_tready;
    assign k_last      = (k_reg == eff_dm1);
    assign j_is_end    = (j_reg == count_reg);
    assign j_is_i      = (j_reg == CNT_W'(i_reg));
    assign i_is_last   = (CNT_W'(i_reg) == count_reg - 1'b1);
    assign j_idx       = j_reg[PI_W-1:0];

    // point store: two copies written together give two read ports
    assign st_we      = in_req && !full;
    assign st_waddr   = SA_W'(count_reg[PI_W-1:0]) * SA_W'(MAX_DIMS) + SA_W'(cidx_reg);
    assign st_raddr_a = SA_W'(i_reg) * SA_W'(MAX_DIMS) + SA_W'(k_reg);
    assign st_raddr_b = SA_W'(j_idx) * SA_W'(MAX_DIMS) + SA_W'(k_reg);

    soig_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS * MAX_DIMS)) u_store_a (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (s_axis_tdata[CW-1:0]),
        .rd_addr (st_raddr_a),
        .rd_data (st_rd_a)
    );

    soig_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS * MAX_DIMS)) u_store_b (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (s_axis_tdata[CW-1:0]),
        .rd_addr (st_raddr_b),
        .rd_data (st_rd_b)
    );

    // nearest squared distance per point, rewritten for every row of the nearest search pass
    assign near_we    = (state_reg == soig_pkg::ST_ROW_END);
    assign near_raddr = (state_reg == soig_pkg::ST_ROW_START) ? i_reg : j_idx;

    soig_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_nearest (
        .clk     (clk),
        .wr_en   (near_we),
        .wr_addr (i_reg),
        .wr_data (min_reg),
        .rd_addr (near_raddr),
        .rd_data (near_rd)
    );

    // shared unit: coordinate difference and its square
    assign diff     = $signed({st_rd_a[CW-1], st_rd_a}) - $signed({st_rd_b[CW-1], st_rd_b});
    assign diff_neg = -diff;
    assign mag      = diff[CW] ? diff_neg[CW-1:0] : diff[CW-1:0];

    // link test against the sum of both squared radii
    assign thr  = {1'b0, near_i_reg} + {1'b0, near_rd};
    assign link = ({1'b0, acc_reg} < thr);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            soig_pkg::ST_IDLE:
            begin
                if (in_req && s_axis_tlast && (count_upd != '0))
                begin
                    state_next = soig_pkg::ST_ROW_START;
                end
            end
            soig_pkg::ST_ROW_START: state_next = soig_pkg::ST_ROW_CAP;
            soig_pkg::ST_ROW_CAP:   state_next = soig_pkg::ST_PAIR_CHK;
            soig_pkg::ST_PAIR_CHK:
            begin
                priority if (j_is_end)
                begin
                    state_next = pass_reg ? soig_pkg::ST_OUT : soig_pkg::ST_ROW_END;
                end
                else if (!j_is_i)
                begin
                    state_next = soig_pkg::ST_ADDR;
                end
            end
            soig_pkg::ST_ADDR: state_next = soig_pkg::ST_DATA;
            soig_pkg::ST_DATA: state_next = soig_pkg::ST_ACC;
            soig_pkg::ST_ACC:  state_next = k_last ? soig_pkg::ST_CMP : soig_pkg::ST_ADDR;
            soig_pkg::ST_CMP:  state_next = soig_pkg::ST_PAIR_CHK;
            soig_pkg::ST_ROW_END: state_next = soig_pkg::ST_ROW_START;
            soig_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = i_is_last ? soig_pkg::ST_IDLE : soig_pkg::ST_ROW_START;
                end
            end
            default: state_next = soig_pkg::ST_IDLE;
        endcase
    end

    // register updates per state
    always_comb
    begin
        pass_next       = pass_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        count_next      = count_reg;
        cidx_next       = cidx_reg;
        dropped_next    = dropped_reg;
        acc_next        = acc_reg;
        sq_next         = sq_reg;
        min_next        = min_reg;
        near_i_next     = near_i_reg;
        mask_next       = mask_reg;
        out_vertex_next = out_vertex_reg;
        out_neigh_next  = out_neigh_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = m_axis_tready ? 1'b0 : out_valid_reg;

        unique case (state_reg)
            soig_pkg::ST_IDLE:
            begin
                if (in_req)
                begin
                    dropped_next = dropped_reg || full;
                    cidx_next    = point_close ? '0 : cidx_reg + 1'b1;
                    count_next   = count_upd;
                    if (s_axis_tlast)
                    begin
                        cidx_next = '0;
                        pass_next = 1'b0;
                        i_next    = '0;
                        // empty set: nothing to report
                        if (count_upd == '0)
                        begin
                            dropped_next = 1'b0;
                        end
                    end
                end
            end
            soig_pkg::ST_ROW_START:
            begin
                j_next    = '0;
                min_next  = soig_pkg::DIST_INF;
                mask_next = '0;
            end
            soig_pkg::ST_ROW_CAP:
            begin
                near_i_next = near_rd;
            end
            soig_pkg::ST_PAIR_CHK:
            begin
                priority if (j_is_end)
                begin
                    j_next = j_reg;
                end
                else if (j_is_i)
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    k_next   = '0;
                    acc_next = '0;
                end
            end
            soig_pkg::ST_ADDR:
            begin
                k_next = k_reg;
            end
            soig_pkg::ST_DATA:
            begin
                sq_next = mag * mag;
            end
            soig_pkg::ST_ACC:
            begin
                acc_next = acc_reg + DW'(sq_reg);
                if (!k_last)
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            soig_pkg::ST_CMP:
            begin
                if (pass_reg)
                begin
                    if (link)
                    begin
                        mask_next[j_idx] = 1'b1;
                    end
                end
                else if (acc_reg < min_reg)
                begin
                    min_next = acc_reg;
                end
                j_next = j_reg + 1'b1;
            end
            soig_pkg::ST_ROW_END:
            begin
                // nearest value goes to memory; start linking after the last row
                if (i_is_last)
                begin
                    pass_next = 1'b1;
                    i_next    = '0;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            soig_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = soig_pkg::VERTEX_W'(i_reg);
                    out_neigh_next  = soig_pkg::NEIGH_W'(mask_reg);
                    out_ovf_next    = dropped_reg;
                    out_last_next   = i_is_last;
                    if (i_is_last)
                    begin
                        count_next   = '0;
                        cidx_next    = '0;
                        dropped_next = 1'b0;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                pass_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= soig_pkg::ST_IDLE;
            pass_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            count_reg     <= '0;
            cidx_reg      <= '0;
            dropped_reg   <= 1'b0;
            dims_reg      <= soig_pkg::DIMS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            cidx_reg      <= cidx_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                dims_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        sq_reg         <= sq_next;
        min_reg        <= min_next;
        near_i_reg     <= near_i_next;
        mask_reg       <= mask_next;
        out_vertex_reg <= out_vertex_next;
        out_neigh_reg  <= out_neigh_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
    end

    // input is taken only while loading
    assign s_axis_tready = (state_reg == soig_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_ovf_reg, out_neigh_reg, out_vertex_reg};
    assign m_axis_tlast  = out_last_reg;

    // last row of a set handed to the output, and the cleared set state after it
    assign row_out_last = (state_reg == soig_pkg::ST_OUT) && out_free && i_is_last;
    assign set_closed   = (count_reg == '0) && !dropped_reg && m_axis_tvalid && m_axis_tlast;

    `SOIG_ASSERT(a_count_in_range, count_reg <= CNT_W'(MAX_POINTS), "count above capacity")
    `SOIG_ASSERT(a_no_self_link, (state_reg != soig_pkg::ST_OUT) || !mask_reg[i_reg], "self link")
    `SOIG_ASSERT(a_cmp_after_last_coord, (state_reg != soig_pkg::ST_CMP) || k_last, "early compare")
    `SOIG_ASSERT_NEXT(a_set_cleared, row_out_last, set_closed, "set not closed after last row")

endmodule
